/* hw/rtl/three_wire_rtc_serial_master_assert.svh */
// assertion macros shared by the rtc serial master rtl
// no dependencies; included by modules that carry assertions
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_ASSERT_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RTCSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtcsm assertion failed");

// antecedent implies consequent in the next cycle
`define RTCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtcsm assertion failed");

`endif

/* hw/rtl/rtcsm_pkg.sv */
// shared types and constants of the rtc serial master
// no dependencies; used by all rtcsm modules
`default_nettype none

package rtcsm_pkg;

  localparam logic [4:0] MAX_BURST = 5'd31;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW = $clog2(QDEPTH);

  // input kind codes as they arrive on tuser
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_TICK  = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_SEND = 4'b0010,
    PH_RECV = 4'b0100,
    PH_HOLD = 4'b1000
  } phase_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] byte_val;
    logic       is_read;
    logic [4:0] count;
    logic       dat_in;
  } item_t;

  typedef struct packed {
    logic       ce;
    logic       sclk;
    logic       dat_oe;
    logic       dat_out;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       waiting;
    logic       busy_res;
    logic       error;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/three_wire_rtc_serial_master.sv */
// top level of the three-wire rtc serial master
// depends on rtcsm_pkg, rtcsm_front, rtcsm_queue and rtcsm_back
`default_nettype none

// Three-wire real-time-clock link master. Each input item is decoded by tuser:
// start (0) raises chip enable and loads the command byte, sent lsb first;
// data (1) supplies the next write byte through a one-byte hold; tick (2) is
// one delay unit of the link and carries the sampled data line. The clock
// rises on one tick and falls on the next while the next bit is set up. A
// write stalls with the clock low (waiting) when no byte is held; a read
// releases the data line on the rise of command bit 7 and reports each received byte
// with read_valid, tlast marking the last one. Every item gives exactly one
// result item with the line levels after it. Items pass a decoder, a
// two-entry queue and a sequencer that retires one item per clock when the
// output is ready, so the block then sustains one item per cycle; a result
// appears in the cycle after its item is taken, and a stalled result register
// holds back only the sequencer while the queue still takes up to two items.
module three_wire_rtc_serial_master (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input item channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // byte_value[7:0] is_read[8] count[13:9] dat_in[14]
  input  wire logic [1:0]  in_tuser,  // kind[1:0]
  // result item channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata, // ce[0] sclk[1] dat_oe[2] dat_out[3] read_valid[4]
                                      // read_data[12:5] waiting[13] busy_res[14] error[15]
  output logic             out_tlast  // read_last
);

  rtcsm_pkg::item_t dec_item;
  rtcsm_pkg::item_t q_item;
  rtcsm_pkg::res_t  res;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             push;

  // decode the raw item
  rtcsm_front u_front (
    .kind_i     (in_tuser),
    .byte_val_i (in_tdata[7:0]),
    .is_read_i  (in_tdata[8]),
    .count_i    (in_tdata[13:9]),
    .dat_in_i   (in_tdata[14]),
    .item_o     (dec_item)
  );

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  // decoupling queue between decoder and sequencer
  rtcsm_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_item_i (dec_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  // link sequencer with its output register
  rtcsm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_res_o   (res)
  );

  // pack the result fields, error in the highest bit and ce in the lowest
  assign out_tdata = {res.error, res.busy_res, res.waiting, res.read_data,
                      res.read_valid, res.dat_out, res.dat_oe, res.sclk, res.ce};
  assign out_tlast = res.read_last;

endmodule

`default_nettype wire

/* hw/rtl/rtcsm_front.sv */
// front end: decodes the item kind and saturates the byte count
// depends on rtcsm_pkg
`default_nettype none

module rtcsm_front (
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  byte_val_i,
  input  wire logic        is_read_i,
  input  wire logic [4:0]  count_i,
  input  wire logic        dat_in_i,
  output rtcsm_pkg::item_t item_o
);

  rtcsm_pkg::op_t op;

  always_comb begin
    unique case (kind_i)
      rtcsm_pkg::KIND_START: op = rtcsm_pkg::OP_START;
      rtcsm_pkg::KIND_DATA:  op = rtcsm_pkg::OP_DATA;
      rtcsm_pkg::KIND_TICK:  op = rtcsm_pkg::OP_TICK;
      default:               op = rtcsm_pkg::OP_BAD;
    endcase
  end

  always_comb begin
    item_o.op       = op;
    item_o.byte_val = byte_val_i;
    item_o.is_read  = is_read_i;
    item_o.count    = (count_i > rtcsm_pkg::MAX_BURST) ? rtcsm_pkg::MAX_BURST : count_i;
    item_o.dat_in   = dat_in_i;
  end

endmodule

`default_nettype wire

/* hw/rtl/rtcsm_queue.sv */
// short fifo of decoded items between front and back
// depends on rtcsm_pkg and the assertion header
`default_nettype none

`include "three_wire_rtc_serial_master_assert.svh"

module rtcsm_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_i,
  input  wire rtcsm_pkg::item_t push_item_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output rtcsm_pkg::item_t      item_o
);

  localparam int unsigned CW = $clog2(rtcsm_pkg::QDEPTH + 1);

  rtcsm_pkg::item_t           mem_r [rtcsm_pkg::QDEPTH];
  logic [rtcsm_pkg::QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [rtcsm_pkg::QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == CW'(rtcsm_pkg::QDEPTH));
  assign valid_o = (cnt_r != '0);
  assign item_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == rtcsm_pkg::QAW'(rtcsm_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == rtcsm_pkg::QAW'(rtcsm_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    priority if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_item_i;
    end
  end

  `RTCSM_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop_i, valid_o)
  `RTCSM_ASSERT_NOW(a_no_push_full, clk, rst_n, push_i, !full_o)
  `RTCSM_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(rtcsm_pkg::QDEPTH))

endmodule

`default_nettype wire

/* hw/rtl/rtcsm_back.sv */
// back end: link sequencer that runs one decoded item per cycle when the
// output is free, holding its result in an output register; depends on rtcsm_pkg
`default_nettype none

`include "three_wire_rtc_serial_master_assert.svh"

module rtcsm_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid_i,
  input  wire rtcsm_pkg::item_t q_item_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rtcsm_pkg::res_t       out_res_o
);

  rtcsm_pkg::phase_t phase_r, phase_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic       clk_lvl_r, clk_lvl_nxt;
  logic       en_r, en_nxt;
  logic       de_r, de_nxt;
  logic       dl_r, dl_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [4:0] left_r, left_nxt;
  logic       reading_r, reading_nxt;
  logic [7:0] held_r, held_nxt;
  logic       held_v_r, held_v_nxt;
  logic       out_valid_r;
  rtcsm_pkg::res_t res_r, res_nxt;

  logic       err, rv, rl;
  logic [7:0] rd, sh;
  rtcsm_pkg::item_t it;

  assign it      = q_item_i;
  assign q_pop_o = q_valid_i && (!out_valid_r || out_ready_i);
  assign sh      = shift_r | (8'(it.dat_in) << bit_r);

  always_comb begin
    phase_nxt   = phase_r;
    bit_nxt     = bit_r;
    clk_lvl_nxt = clk_lvl_r;
    en_nxt      = en_r;
    de_nxt      = de_r;
    dl_nxt      = dl_r;
    shift_nxt   = shift_r;
    left_nxt    = left_r;
    reading_nxt = reading_r;
    held_nxt    = held_r;
    held_v_nxt  = held_v_r;
    err = 1'b0;
    rv  = 1'b0;
    rl  = 1'b0;
    rd  = '0;
    unique case (it.op)
      rtcsm_pkg::OP_START: begin
        if (phase_r != rtcsm_pkg::PH_IDLE) begin
          err = 1'b1;
        end else begin
          en_nxt      = 1'b1;
          clk_lvl_nxt = 1'b0;
          reading_nxt = it.is_read;
          left_nxt    = it.count;
          held_v_nxt  = 1'b0;
          shift_nxt   = it.byte_val;
          bit_nxt     = '0;
          de_nxt      = 1'b1;
          dl_nxt      = it.byte_val[0];
          phase_nxt   = rtcsm_pkg::PH_SEND;
        end
      end
      rtcsm_pkg::OP_DATA: begin
        priority if (phase_r == rtcsm_pkg::PH_HOLD) begin
          shift_nxt = it.byte_val;
          bit_nxt   = '0;
          de_nxt    = 1'b1;
          dl_nxt    = it.byte_val[0];
          left_nxt  = (left_r != '0) ? left_r - 1'b1 : left_r;
          phase_nxt = rtcsm_pkg::PH_SEND;
        end else if (phase_r == rtcsm_pkg::PH_SEND && !reading_r && !held_v_r &&
                     left_r != '0) begin
          held_nxt   = it.byte_val;
          held_v_nxt = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      rtcsm_pkg::OP_TICK: begin
        if (phase_r == rtcsm_pkg::PH_SEND) begin
          if (!clk_lvl_r) begin
            clk_lvl_nxt = 1'b1;
            if (bit_r == 3'd7 && reading_r) begin
              // release the line on the rise of command bit 7
              de_nxt    = 1'b0;
              dl_nxt    = 1'b0;
              shift_nxt = '0;
              bit_nxt   = '0;
              phase_nxt = rtcsm_pkg::PH_RECV;
            end
          end else begin
            clk_lvl_nxt = 1'b0;
            priority if (bit_r != 3'd7) begin
              bit_nxt = bit_r + 1'b1;
              dl_nxt  = shift_r[bit_r + 3'd1];
            end else if (left_r == '0) begin
              phase_nxt   = rtcsm_pkg::PH_IDLE;
              en_nxt      = 1'b0;
              de_nxt      = 1'b0;
              dl_nxt      = 1'b0;
              bit_nxt     = '0;
              reading_nxt = 1'b0;
            end else if (held_v_r) begin
              held_v_nxt = 1'b0;
              shift_nxt  = held_r;
              bit_nxt    = '0;
              de_nxt     = 1'b1;
              dl_nxt     = held_r[0];
              left_nxt   = left_r - 1'b1;
            end else begin
              phase_nxt = rtcsm_pkg::PH_HOLD;
            end
          end
        end else if (phase_r == rtcsm_pkg::PH_RECV) begin
          priority if (clk_lvl_r) begin
            clk_lvl_nxt = 1'b0;
            if (left_r == '0) begin
              phase_nxt   = rtcsm_pkg::PH_IDLE;
              en_nxt      = 1'b0;
              de_nxt      = 1'b0;
              dl_nxt      = 1'b0;
              bit_nxt     = '0;
              reading_nxt = 1'b0;
            end
          end else if (left_r != '0) begin
            if (bit_r != 3'd7) begin
              shift_nxt   = sh;
              bit_nxt     = bit_r + 1'b1;
              clk_lvl_nxt = 1'b1;
            end else begin
              rv       = 1'b1;
              rd       = sh;
              left_nxt = left_r - 1'b1;
              rl       = (left_r == 5'd1);
              if (rl) begin
                shift_nxt   = sh;
                phase_nxt   = rtcsm_pkg::PH_IDLE;
                clk_lvl_nxt = 1'b0;
                en_nxt      = 1'b0;
                de_nxt      = 1'b0;
                dl_nxt      = 1'b0;
                bit_nxt     = '0;
                reading_nxt = 1'b0;
              end else begin
                shift_nxt   = '0;
                bit_nxt     = '0;
                clk_lvl_nxt = 1'b1;
              end
            end
          end else begin
            phase_nxt   = rtcsm_pkg::PH_IDLE;
            clk_lvl_nxt = 1'b0;
            en_nxt      = 1'b0;
            de_nxt      = 1'b0;
            dl_nxt      = 1'b0;
            bit_nxt     = '0;
            reading_nxt = 1'b0;
          end
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    res_nxt.ce         = en_nxt;
    res_nxt.sclk       = clk_lvl_nxt;
    res_nxt.dat_oe     = de_nxt;
    res_nxt.dat_out    = de_nxt & dl_nxt;
    res_nxt.read_valid = rv;
    res_nxt.read_data  = rd;
    res_nxt.read_last  = rl;
    res_nxt.waiting    = (phase_nxt == rtcsm_pkg::PH_HOLD);
    res_nxt.busy_res   = (phase_nxt != rtcsm_pkg::PH_IDLE);
    res_nxt.error      = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rtcsm_pkg::PH_IDLE;
      bit_r       <= '0;
      clk_lvl_r   <= 1'b0;
      en_r        <= 1'b0;
      de_r        <= 1'b0;
      dl_r        <= 1'b0;
      shift_r     <= '0;
      left_r      <= '0;
      reading_r   <= 1'b0;
      held_r      <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop_o) begin
        phase_r   <= phase_nxt;
        bit_r     <= bit_nxt;
        clk_lvl_r <= clk_lvl_nxt;
        en_r      <= en_nxt;
        de_r      <= de_nxt;
        dl_r      <= dl_nxt;
        shift_r   <= shift_nxt;
        left_r    <= left_nxt;
        reading_r <= reading_nxt;
        held_r    <= held_nxt;
        held_v_r  <= held_v_nxt;
      end
      if (q_pop_o) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_res_o   = res_r;

  `RTCSM_ASSERT_NOW(a_ce_tracks_busy, clk, rst_n, 1'b1, en_r == (phase_r != rtcsm_pkg::PH_IDLE))
  `RTCSM_ASSERT_NOW(a_hold_clock_low, clk, rst_n, phase_r == rtcsm_pkg::PH_HOLD, !clk_lvl_r)
  `RTCSM_ASSERT_NOW(a_recv_released, clk, rst_n, phase_r == rtcsm_pkg::PH_RECV, !de_r && reading_r)
  `RTCSM_ASSERT_NEXT(a_stall_holds_state, clk, rst_n, !q_pop_o, $stable(phase_r) && $stable(bit_r))

endmodule

`default_nettype wire
